// File: sv/fdtd_vsu_pkg.sv
package fdtd_vsu_pkg;

  // Field and word geometry
  localparam int Q_W     = 32;
  localparam int N_LANES = 3;
  localparam int N_IN    = 12;
  localparam int IN_W    = N_IN * Q_W;
  localparam int OUT_W   = N_LANES * Q_W;

  // Offsets of the field groups inside the input word, in fields
  localparam int F_VOLT = 0;
  localparam int F_VV   = 3;
  localparam int F_VI   = 6;
  localparam int F_CURR = 9;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SIZE_W     = 11;
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd64;

  // Default grid limits
  localparam int DEF_MAX_I = 64;
  localparam int DEF_MAX_J = 64;
  localparam int DEF_MAX_K = 64;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_I = 2'd0,
    REG_SIZE_J = 2'd1,
    REG_SIZE_K = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Currents of the cell and of its three neighbors, border already resolved
  typedef struct packed {
    q_t   c0;
    q_t   c1;
    q_t   c2;
    q_t   c0_pk;
    q_t   c1_pk;
    q_t   c0_pj;
    q_t   c2_pj;
    q_t   c1_pi;
    q_t   c2_pi;
    logic done;
  } nbr_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } lane_en_t;

  // One lane computes volt*vv + vi*sat(p - pn - q + qn)
  typedef struct packed {
    q_t volt;
    q_t vv;
    q_t vi;
    q_t p;
    q_t pn;
    q_t q;
    q_t qn;
  } lane_in_t;

  // Saturate a signed value to the Q16.16 range.
  function automatic q_t sat_q(input logic signed [63:0] x);
    if (x > 64'(Q_MAX)) begin
      return Q_MAX;
    end
    if (x < 64'(Q_MIN)) begin
      return Q_MIN;
    end
    return q_t'(x[Q_W-1:0]);
  endfunction

endpackage

// File: sv/fdtd_voltage_stencil_update_top.sv
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid / s_tready  s_tdata: 12 fields of 32 bits (cell)
// m_*      out  m_tvalid / m_tready  m_tdata: 3 fields of 32 bits, m_tlast: grid_done
// cfg_*    in   cfg_wr_en, no wait   cfg_index selects size_i/j/k, cfg_data is the size
//
// One cell per cycle sustained while m_tready is high; a result crosses stages 1 to 4.
// The line and plane stores are read and written at the same address in the
// accepting cycle, one access of each per cell, which sets the one-word rate.
// Reset is synchronous: it empties the pipeline, returns the position to the
// origin and sets all sizes to 64. The stores need no clearing pass.
// Stages close bubbles; with m_tready low the output word holds and s_tready
// drops once all four stages are full.
module fdtd_voltage_stencil_update_top #(
  parameter int MAX_I = fdtd_vsu_pkg::DEF_MAX_I,
  parameter int MAX_J = fdtd_vsu_pkg::DEF_MAX_J,
  parameter int MAX_K = fdtd_vsu_pkg::DEF_MAX_K
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // volt_x, volt_y, volt_z, coef_vv_x, coef_vv_y, coef_vv_z,
  // coef_vi_x, coef_vi_y, coef_vi_z, curr_x, curr_y, curr_z
  input  logic [fdtd_vsu_pkg::IN_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // new_volt_x, new_volt_y, new_volt_z
  output logic [fdtd_vsu_pkg::OUT_W-1:0]      m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_wr_en,
  input  logic [fdtd_vsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdtd_vsu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdtd_vsu_pkg::*;

  q_t       in_f [N_IN];
  q_t       volt1 [N_LANES];
  q_t       vv1 [N_LANES];
  q_t       vi1 [N_LANES];
  q_t       res [N_LANES];
  lane_in_t lin [N_LANES];
  lane_en_t len;
  cfg_wr_t  cfg;
  nbr_t     nb;
  logic     acc;
  logic     v1;
  logic     v2;
  logic     v3;
  logic     v4;
  logic     rdy1;
  logic     rdy2;
  logic     rdy3;
  logic     rdy4;
  logic     done2;
  logic     done3;
  logic     out_last;
  logic [OUT_W-1:0] out_data;

  // Split the input word into fields.
  always_comb begin
    for (int n = 0; n < N_IN; n++) begin
      in_f[n] = s_tdata[n*Q_W +: Q_W];
    end
  end

  // Pipeline flow: a stage takes a word when it is empty or its successor moves.
  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign acc      = s_tvalid && rdy1;
  assign len.s2   = rdy2 && v1;
  assign len.s3   = rdy3 && v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1 keeps the per-cell voltages and coefficients.
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int n = 0; n < N_LANES; n++) begin
        volt1[n] <= in_f[F_VOLT + n];
        vv1[n]   <= in_f[F_VV + n];
        vi1[n]   <= in_f[F_VI + n];
      end
    end
  end

  assign cfg.en    = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  fdtd_vsu_nbr #(
    .MAX_I (MAX_I),
    .MAX_J (MAX_J),
    .MAX_K (MAX_K)
  ) u_nbr (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .acc   (acc),
    .cur_x (in_f[F_CURR]),
    .cur_y (in_f[F_CURR + 1]),
    .cur_z (in_f[F_CURR + 2]),
    .nb    (nb)
  );

  // Curl terms per polarization.
  always_comb begin
    lin[0] = '{volt: volt1[0], vv: vv1[0], vi: vi1[0],
               p: nb.c2, pn: nb.c2_pj, q: nb.c1, qn: nb.c1_pk};
    lin[1] = '{volt: volt1[1], vv: vv1[1], vi: vi1[1],
               p: nb.c0, pn: nb.c0_pk, q: nb.c2, qn: nb.c2_pi};
    lin[2] = '{volt: volt1[2], vv: vv1[2], vi: vi1[2],
               p: nb.c1, pn: nb.c1_pi, q: nb.c0, qn: nb.c0_pj};
  end

  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    fdtd_vsu_lane u_lane (
      .clk    (clk),
      .en     (len),
      .din    (lin[g]),
      .result (res[g])
    );
  end

  // The grid-end flag follows its cell through the lanes.
  always_ff @(posedge clk) begin
    if (len.s2) done2 <= nb.done;
    if (len.s3) done3 <= done2;
  end

  // Merge the lane results into the output word.
  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      out_data <= {res[2], res[1], res[0]};
      out_last <= done3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  // An empty first stage always takes a word.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_tready)
    else $error("first stage empty but not ready");

  // A full pipeline with a stalled output must not take a word.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && !m_tready |-> !s_tready)
    else $error("word taken into a full pipeline");

  // An accepted word lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    acc |=> v1)
    else $error("accepted word lost");

  // A word in stage 3 stays put while stage 4 cannot take it.
  a_hold_s3: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy4 |=> v3)
    else $error("stage 3 word dropped during stall");

endmodule

// File: sv/fdtd_vsu_lane.sv
module fdtd_vsu_lane (
  input  logic                  clk,
  input  fdtd_vsu_pkg::lane_en_t en,
  input  fdtd_vsu_pkg::lane_in_t din,
  output fdtd_vsu_pkg::q_t       result
);
  import fdtd_vsu_pkg::*;

  localparam int CURL_W  = Q_W + 3;
  localparam int PROD_W  = 2 * Q_W;
  localparam int FRAC    = 16;
  localparam int TRUNC_W = PROD_W - FRAC;
  localparam int SUM_W   = TRUNC_W + 1;

  logic signed [CURL_W-1:0]  curl_sum;
  q_t                        volt2;
  q_t                        vv2;
  q_t                        vi2;
  q_t                        curl2;
  logic signed [PROD_W-1:0]  prod_a;
  logic signed [PROD_W-1:0]  prod_b;
  logic signed [TRUNC_W-1:0] ta3;
  logic signed [TRUNC_W-1:0] tb3;
  logic signed [SUM_W-1:0]   sum3;

  // Curl of the current: four-term exact sum.
  assign curl_sum = CURL_W'($signed(din.p)) - CURL_W'($signed(din.pn))
                  - CURL_W'($signed(din.q)) + CURL_W'($signed(din.qn));

  // Stage 2 holds the operands and the saturated curl.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      volt2 <= din.volt;
      vv2   <= din.vv;
      vi2   <= din.vi;
      curl2 <= sat_q(64'(curl_sum));
    end
  end

  // Two products in parallel; dropping the fraction bits floors them.
  assign prod_a = PROD_W'(volt2) * PROD_W'(vv2);
  assign prod_b = PROD_W'(vi2) * PROD_W'(curl2);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ta3 <= prod_a[PROD_W-1:FRAC];
      tb3 <= prod_b[PROD_W-1:FRAC];
    end
  end

  // Saturating sum of the truncated products.
  assign sum3   = SUM_W'(ta3) + SUM_W'(tb3);
  assign result = sat_q(64'(sum3));

endmodule

// File: sv/fdtd_vsu_nbr.sv
module fdtd_vsu_nbr #(
  parameter int MAX_I = fdtd_vsu_pkg::DEF_MAX_I,
  parameter int MAX_J = fdtd_vsu_pkg::DEF_MAX_J,
  parameter int MAX_K = fdtd_vsu_pkg::DEF_MAX_K
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fdtd_vsu_pkg::cfg_wr_t cfg,
  input  logic                  acc,
  input  fdtd_vsu_pkg::q_t      cur_x,
  input  fdtd_vsu_pkg::q_t      cur_y,
  input  fdtd_vsu_pkg::q_t      cur_z,
  output fdtd_vsu_pkg::nbr_t    nb
);
  import fdtd_vsu_pkg::*;

  localparam int IW  = (MAX_I > 1) ? $clog2(MAX_I) : 1;
  localparam int JW  = (MAX_J > 1) ? $clog2(MAX_J) : 1;
  localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int PD  = MAX_J * MAX_K;
  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;

  // Last index on an axis from a written size: zero reads as one, large values clamp.
  function automatic logic [SIZE_W-1:0] last_of(input logic [CFG_DATA_W-1:0] d,
                                                input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] v;
    v = SIZE_W'(d);
    if (v == '0) begin
      v = SIZE_W'(1);
    end
    if (v > lim) begin
      v = lim;
    end
    return v - SIZE_W'(1);
  endfunction

  logic [IW-1:0]      last_i;
  logic [JW-1:0]      last_j;
  logic [KW-1:0]      last_k;
  logic [IW-1:0]      pos_i;
  logic [JW-1:0]      pos_j;
  logic [KW-1:0]      pos_k;
  logic               wk;
  logic               wj;
  logic               wi;
  logic [PAW-1:0]     paddr;
  logic [2*Q_W-1:0]   pk;
  logic [2*Q_W-1:0]   pk_q;
  logic [2*Q_W-1:0]   line_mem [MAX_K];
  logic [2*Q_W-1:0]   plane_mem [PD];
  logic [2*Q_W-1:0]   line_rd;
  logic [2*Q_W-1:0]   plane_rd;
  q_t                 cx_q;
  q_t                 cy_q;
  q_t                 cz_q;
  logic               kz_q;
  logic               jz_q;
  logic               iz_q;
  logic               done_q;

  // Size registers, kept as last index per axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_i <= IW'(last_of(SIZE_RESET, SIZE_W'(MAX_I)));
      last_j <= JW'(last_of(SIZE_RESET, SIZE_W'(MAX_J)));
      last_k <= KW'(last_of(SIZE_RESET, SIZE_W'(MAX_K)));
    end else if (cfg.en) begin
      case (cfg.index)
        REG_SIZE_I: last_i <= IW'(last_of(cfg.data, SIZE_W'(MAX_I)));
        REG_SIZE_J: last_j <= JW'(last_of(cfg.data, SIZE_W'(MAX_J)));
        REG_SIZE_K: last_k <= KW'(last_of(cfg.data, SIZE_W'(MAX_K)));
        default: ;
      endcase
    end
  end

  // Wrap decisions; a position past a shrunk size wraps as well.
  assign wk = (pos_k >= last_k);
  assign wj = wk && (pos_j >= last_j);
  assign wi = wj && (pos_i >= last_i);

  // Raster position and the previous-k register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_i <= '0;
      pos_j <= '0;
      pos_k <= '0;
      pk    <= '0;
    end else if (acc) begin
      pk <= {cur_y, cur_x};
      if (!wk) begin
        pos_k <= pos_k + KW'(1);
      end else begin
        pos_k <= '0;
        if (!wj) begin
          pos_j <= pos_j + JW'(1);
        end else begin
          pos_j <= '0;
          pos_i <= wi ? '0 : pos_i + IW'(1);
        end
      end
    end
  end

  assign paddr = PAW'(pos_j) * PAW'(MAX_K) + PAW'(pos_k);

  // Line and plane stores: the entry is read before this cell overwrites it.
  always_ff @(posedge clk) begin
    if (acc) begin
      line_rd         <= line_mem[pos_k];
      line_mem[pos_k] <= {cur_z, cur_x};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      plane_rd         <= plane_mem[paddr];
      plane_mem[paddr] <= {cur_z, cur_y};
    end
  end

  // Cell currents and border flags travel with the store read data.
  always_ff @(posedge clk) begin
    if (acc) begin
      cx_q   <= cur_x;
      cy_q   <= cur_y;
      cz_q   <= cur_z;
      pk_q   <= pk;
      kz_q   <= (pos_k == '0);
      jz_q   <= (pos_j == '0);
      iz_q   <= (pos_i == '0);
      done_q <= wi;
    end
  end

  // At the low border of an axis the neighbor is the cell itself.
  always_comb begin
    nb.c0    = cx_q;
    nb.c1    = cy_q;
    nb.c2    = cz_q;
    nb.c0_pk = kz_q ? cx_q : pk_q[Q_W-1:0];
    nb.c1_pk = kz_q ? cy_q : pk_q[2*Q_W-1:Q_W];
    nb.c0_pj = jz_q ? cx_q : line_rd[Q_W-1:0];
    nb.c2_pj = jz_q ? cz_q : line_rd[2*Q_W-1:Q_W];
    nb.c1_pi = iz_q ? cy_q : plane_rd[Q_W-1:0];
    nb.c2_pi = iz_q ? cz_q : plane_rd[2*Q_W-1:Q_W];
    nb.done  = done_q;
  end

  // The k position steps by one inside a row.
  a_k_step: assert property (@(posedge clk) disable iff (rst)
    acc && !wk |=> pos_k == $past(pos_k) + KW'(1))
    else $error("k position did not advance");

  // The last cell of the grid returns the position to the origin.
  a_grid_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && wi |=> pos_i == '0 && pos_j == '0 && pos_k == '0)
    else $error("position not cleared after last cell");

  // Without an accepted word the position holds.
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(pos_i) && $stable(pos_j) && $stable(pos_k))
    else $error("position moved without an accepted word");

endmodule
